FILE: rtl/cac_pkg.sv
package cac_pkg;

    localparam int TempWidth   = 11;
    localparam int PctWidth    = 7;
    localparam int StreakWidth = 8;
    localparam int TimeWidth   = 32;
    localparam int CfgIdxWidth = 3;
    localparam int CfgWidth    = 11;

    localparam logic [TimeWidth-1:0] CritPeriod = 32'd1000;
    localparam logic [TimeWidth-1:0] WarnPeriod = 32'd10000;
    localparam logic [TimeWidth-1:0] CritLen    = 32'd200;
    localparam logic [TimeWidth-1:0] WarnLen    = 32'd80;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_MUTE   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ALARM_OK   = 2'd0,
        ALARM_WARN = 2'd1,
        ALARM_CRIT = 2'd2
    } alarm_t;

    typedef enum logic {
        TONE_1K = 1'b0,
        TONE_2K = 1'b1
    } tone_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_FAN_ON_TEMP      = 3'd0,
        CFG_FAN_OFF_TEMP     = 3'd1,
        CFG_LIGHT_ON_PCT     = 3'd2,
        CFG_LIGHT_OFF_PCT    = 3'd3,
        CFG_ALARM_TEMP       = 3'd4,
        CFG_SOIL_DRY_PCT     = 3'd5,
        CFG_MAX_FAIL_STREAK  = 3'd6,
        CFG_RELAY_ACTIVE_LOW = 3'd7
    } cfg_idx_t;

endpackage

FILE: rtl/climate_alarm_controller_unit.sv
// channel  | direction | handshake          | payload
// s_       | in        | s_valid / s_ready  | op, now_ms, reading_ok, temp, light, soil, streak
// m_       | out       | m_valid / m_ready  | fan, relay, lamp, alarm level, mute, buzzer, tone
// cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
//
// one word per cycle while no result stalls: the input register feeds the comparators,
// alarm ranking and beep timer, which update the state and load the result register
// when the word leaves the input register; mute toggles make no result.
// synchronous active-low reset clears latches, timers and valid flags; config gets defaults.
// a stalled result holds the input register unless it holds a mute toggle;
// s_ready stays high while the input register is empty or moving.
module climate_alarm_controller_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [cac_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [cac_pkg::CfgWidth-1:0]          cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic [cac_pkg::TimeWidth-1:0]         s_now_ms,
    input  logic                                  s_reading_ok,
    input  logic signed [cac_pkg::TempWidth-1:0]  s_temperature,
    input  logic [cac_pkg::PctWidth-1:0]          s_light_pct,
    input  logic [cac_pkg::PctWidth-1:0]          s_soil_pct,
    input  logic [cac_pkg::StreakWidth-1:0]       s_fail_streak,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_fan_on,
    output logic                                  m_relay_level,
    output logic                                  m_lamp_on,
    output logic [1:0]                            m_alarm_level,
    output logic                                  m_mute_flag,
    output logic                                  m_buzzer_on,
    output logic                                  m_buzzer_tone
);
    import cac_pkg::*;

    // configuration
    logic signed [TempWidth-1:0] fan_on_temp_reg, fan_off_temp_reg, alarm_temp_reg;
    logic [PctWidth-1:0]         light_on_pct_reg, light_off_pct_reg, soil_dry_pct_reg;
    logic [StreakWidth-1:0]      max_fail_streak_reg;
    logic                        relay_active_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_on_temp_reg      <= 11'sd300;
            fan_off_temp_reg     <= 11'sd280;
            light_on_pct_reg     <= 7'd30;
            light_off_pct_reg    <= 7'd40;
            alarm_temp_reg       <= 11'sd350;
            soil_dry_pct_reg     <= 7'd20;
            max_fail_streak_reg  <= 8'd3;
            relay_active_low_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FAN_ON_TEMP:      fan_on_temp_reg      <= cfg_wdata;
                CFG_FAN_OFF_TEMP:     fan_off_temp_reg     <= cfg_wdata;
                CFG_LIGHT_ON_PCT:     light_on_pct_reg     <= cfg_wdata[PctWidth-1:0];
                CFG_LIGHT_OFF_PCT:    light_off_pct_reg    <= cfg_wdata[PctWidth-1:0];
                CFG_ALARM_TEMP:       alarm_temp_reg       <= cfg_wdata;
                CFG_SOIL_DRY_PCT:     soil_dry_pct_reg     <= cfg_wdata[PctWidth-1:0];
                CFG_MAX_FAIL_STREAK:  max_fail_streak_reg  <= cfg_wdata[StreakWidth-1:0];
                CFG_RELAY_ACTIVE_LOW: relay_active_low_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    logic                        in_valid_reg;
    op_t                         op_reg;
    logic [TimeWidth-1:0]        now_reg;
    logic                        ok_reg;
    logic signed [TempWidth-1:0] temp_reg;
    logic [PctWidth-1:0]         light_reg, soil_reg;
    logic [StreakWidth-1:0]      streak_reg;

    logic advance;
    assign advance = in_valid_reg && (op_reg == OP_MUTE || !m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg     <= op_t'(s_op);
            now_reg    <= s_now_ms;
            ok_reg     <= s_reading_ok;
            temp_reg   <= s_temperature;
            light_reg  <= s_light_pct;
            soil_reg   <= s_soil_pct;
            streak_reg <= s_fail_streak;
        end
    end

    // state
    logic                 fan_reg, lamp_reg, mute_reg, buzz_reg;
    tone_t                tone_reg;
    logic [TimeWidth-1:0] off_time_reg, last_beep_reg;

    logic                 fan_next, lamp_next, mute_next, buzz_next;
    tone_t                tone_next;
    logic [TimeWidth-1:0] off_time_next, last_beep_next;
    alarm_t               level;
    logic [TimeWidth-1:0] since_off, since_beep;

    assign since_off  = now_reg - off_time_reg;
    assign since_beep = now_reg - last_beep_reg;

    always_comb begin
        fan_next       = fan_reg;
        lamp_next      = lamp_reg;
        mute_next      = mute_reg;
        buzz_next      = buzz_reg;
        tone_next      = tone_reg;
        off_time_next  = off_time_reg;
        last_beep_next = last_beep_reg;
        level          = ALARM_OK;

        if (op_reg == OP_MUTE) begin
            mute_next = !mute_reg;
        end else begin
            if (!ok_reg) begin
                fan_next = 1'b0;
            end else if (!fan_reg) begin
                fan_next = (temp_reg >= fan_on_temp_reg);
            end else begin
                fan_next = !(temp_reg <= fan_off_temp_reg);
            end

            if (!lamp_reg) begin
                lamp_next = (light_reg <= light_on_pct_reg);
            end else begin
                lamp_next = !(light_reg >= light_off_pct_reg);
            end

            priority if (streak_reg >= max_fail_streak_reg
                         || (ok_reg && temp_reg >= alarm_temp_reg)) begin
                level = ALARM_CRIT;
            end else if (soil_reg <= soil_dry_pct_reg) begin
                level = ALARM_WARN;
            end else begin
                level = ALARM_OK;
            end

            if (level == ALARM_OK) begin
                mute_next = 1'b0;
            end

            // beep ends once the off time is reached, signed wrap compare
            if (buzz_reg && !since_off[TimeWidth-1]) begin
                buzz_next = 1'b0;
            end

            if (level == ALARM_CRIT && !mute_next) begin
                if (since_beep >= CritPeriod) begin
                    last_beep_next = now_reg;
                    off_time_next  = now_reg + CritLen;
                    buzz_next      = 1'b1;
                    tone_next      = TONE_2K;
                end
            end else if (level == ALARM_WARN && !mute_next) begin
                if (since_beep >= WarnPeriod) begin
                    last_beep_next = now_reg;
                    off_time_next  = now_reg + WarnLen;
                    buzz_next      = 1'b1;
                    tone_next      = TONE_1K;
                end
            end else begin
                buzz_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_reg       <= 1'b0;
            lamp_reg      <= 1'b0;
            mute_reg      <= 1'b0;
            buzz_reg      <= 1'b0;
            tone_reg      <= TONE_1K;
            off_time_reg  <= '0;
            last_beep_reg <= '0;
        end else if (advance) begin
            fan_reg       <= fan_next;
            lamp_reg      <= lamp_next;
            mute_reg      <= mute_next;
            buzz_reg      <= buzz_next;
            tone_reg      <= tone_next;
            off_time_reg  <= off_time_next;
            last_beep_reg <= last_beep_next;
        end
    end

    // result register
    logic   out_valid_reg;
    logic   out_fan_reg, out_relay_reg, out_lamp_reg, out_mute_reg, out_buzz_reg;
    alarm_t out_level_reg;
    tone_t  out_tone_reg;
    logic   load_out;

    assign load_out = advance && op_reg == OP_UPDATE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_fan_reg   <= fan_next;
            out_relay_reg <= fan_next ^ relay_active_low_reg;
            out_lamp_reg  <= lamp_next;
            out_level_reg <= level;
            out_mute_reg  <= mute_next;
            out_buzz_reg  <= buzz_next;
            out_tone_reg  <= tone_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_fan_on      = out_fan_reg;
    assign m_relay_level = out_relay_reg;
    assign m_lamp_on     = out_lamp_reg;
    assign m_alarm_level = out_level_reg;
    assign m_mute_flag   = out_mute_reg;
    assign m_buzzer_on   = out_buzz_reg;
    assign m_buzzer_tone = out_tone_reg;

`ifndef SYNTHESIS
    // buzzer only sounds on an unmuted warning or critical alarm
    a_buzz_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_buzzer_on |-> m_alarm_level != ALARM_OK && !m_mute_flag)
        else $error("buzzer on without an unmuted alarm");

    // an ok alarm always clears mute
    a_ok_clears_mute: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alarm_level == ALARM_OK |-> !m_mute_flag)
        else $error("mute reported with alarm ok");

    // a mute toggle never loads the result register
    a_mute_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && op_reg == OP_MUTE && !m_valid |=> !m_valid)
        else $error("mute toggle produced a result word");

    // the state only moves when a word leaves the input register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(last_beep_reg) && $stable(mute_reg))
        else $error("state changed without a word");
`endif

endmodule
